// ===== hdl/css_pkg.sv =====
// -----------------------------------------------------------------------------
// css_pkg: shared types and constants for the color sphere segmenter
// Action codes, controller states and the command/status structs.
// -----------------------------------------------------------------------------
package css_pkg;

   localparam int MAX_SAMPLES_DEFAULT   = 4096;
   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int CHANNELS              = 3;

   typedef enum logic [1:0] {
      ACT_SAMPLE   = 2'd0,
      ACT_CLASSIFY = 2'd1,
      ACT_CLEAR    = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RAD,
      ST_DIST,
      ST_CMP,
      ST_OUT,
      ST_RACC,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch pixel word
      logic add_sample;
      logic clear_stats;
      logic div_start;   // start division of current channel
      logic div_step;    // one quotient bit
      logic div_store;   // store quotient as center
      logic sq_max;      // square the center against the channel maximum
      logic rad_acc;     // accumulate radius term of current channel
      logic rad_clr;
      logic dist_acc;    // accumulate distance term of current channel
      logic dist_clr;
      logic fit_done;
      logic [1:0] chan;
      logic load_out;    // load result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic stats_changed;
      logic div_last;
   } status_type;

endpackage

// ===== hdl/color_sphere_segmenter.sv =====
// -----------------------------------------------------------------------------
// color_sphere_segmenter: learns a color sphere and masks pixels against it
// Sample, clear and classify words in; one mask word out per classify.
// -----------------------------------------------------------------------------
// Classify computes the distance and compares it with the radius; an untrained classify
// skips the arithmetic and answers with a zero mask. A classify after changed statistics
// first refits the sphere, running each channel through the bit-serial divider.
// One word in flight; a waiting mask word stalls only the next classify result.
// Synchronous active-high reset clears all statistics and the fitted sphere.
module color_sphere_segmenter #(
   parameter int MAX_SAMPLES   = css_pkg::MAX_SAMPLES_DEFAULT,
   parameter int FRACTION_BITS = css_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // action[1:0], channel_0, channel_1, channel_2
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // mask_value[7:0]
   output logic        rsp_tuser    // untrained
);
   css_pkg::cmd_type    cmd;
   css_pkg::status_type status;
   logic in_sphere, untrained_in;
   logic       valid_ff;
   logic [7:0] mask_ff;
   logic       untr_ff;

   css_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_action(req_tdata[1:0]), .in_ready(req_tready),
      .out_busy(valid_ff && !rsp_tready),
      .status(status), .cmd(cmd), .untrained_in(untrained_in)
   );

   css_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .ch0(req_tdata[9:2]), .ch1(req_tdata[17:10]), .ch2(req_tdata[25:18]),
      .status(status), .in_sphere(in_sphere)
   );

   // hold result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         untr_ff <= untrained_in;
         mask_ff <= (!untrained_in && in_sphere) ? 8'd255 : 8'd0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = mask_ff;
   assign rsp_tuser  = untr_ff;
endmodule

// ===== hdl/css_datapath.sv =====
// -----------------------------------------------------------------------------
// css_datapath: statistics, shared serial divider and distance arithmetic
// One channel per step: restoring division one bit a cycle, one square a cycle.
// -----------------------------------------------------------------------------
module css_datapath #(
   parameter int MAX_SAMPLES   = css_pkg::MAX_SAMPLES_DEFAULT,
   parameter int FRACTION_BITS = css_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  css_pkg::cmd_type     cmd,
   input  logic [7:0]           ch0,
   input  logic [7:0]           ch1,
   input  logic [7:0]           ch2,
   output css_pkg::status_type  status,
   output logic                 in_sphere
);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = 8 + CW;                   // sum width
   localparam int NW = SW + FRACTION_BITS;       // numerator / quotient width
   localparam int VW = 8 + FRACTION_BITS;        // scaled value width
   localparam int DW = 2 * VW + 2;               // accumulated square width
   localparam int QCW = $clog2(NW + 1);

   logic [SW-1:0] sum_ff [3];
   logic [7:0]    max_ff [3];
   logic [CW-1:0] count_ff;
   logic          changed_ff;
   logic [VW-1:0] center_ff [3];
   logic [DW-1:0] radius_ff, dist_ff, radius_in;
   logic [7:0]    px_ff [3];

   // divider
   logic [NW-1:0]  quot_ff;
   logic [CW:0]    rem_ff;
   logic [QCW-1:0] bit_ff;
   logic [CW:0]    trial;
   logic [NW-1:0]  num;

   logic [VW-1:0] a_val, b_val, diff;
   logic [2*VW-1:0] sq_ff;

   assign num   = {sum_ff[cmd.chan], {FRACTION_BITS{1'b0}}};
   assign trial = {rem_ff[CW-1:0], quot_ff[NW-1]};

   // pick operands for the squared difference
   always_comb begin
      a_val = center_ff[cmd.chan];
      if (cmd.sq_max) b_val = {max_ff[cmd.chan], {FRACTION_BITS{1'b0}}};
      else            b_val = {px_ff[cmd.chan], {FRACTION_BITS{1'b0}}};
      diff = (a_val >= b_val) ? a_val - b_val : b_val - a_val;
   end

   assign radius_in = radius_ff + DW'(sq_ff);

   // statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         changed_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            sum_ff[c]    <= '0;
            max_ff[c]    <= '0;
            center_ff[c] <= '0;
         end
         radius_ff <= '0;
      end else begin
         if (cmd.clear_stats) begin
            count_ff   <= '0;
            changed_ff <= 1'b1;
            for (int c = 0; c < 3; c++) begin
               sum_ff[c] <= '0;
               max_ff[c] <= '0;
            end
         end else if (cmd.add_sample) begin
            count_ff   <= count_ff + 1'b1;
            changed_ff <= 1'b1;
            for (int c = 0; c < 3; c++) begin
               sum_ff[c] <= sum_ff[c] + SW'(px_ff[c]);
               if (px_ff[c] > max_ff[c]) max_ff[c] <= px_ff[c];
            end
         end
         if (cmd.div_store) center_ff[cmd.chan] <= quot_ff[VW-1:0];
         if (cmd.rad_clr) radius_ff <= '0;
         else if (cmd.rad_acc) radius_ff <= radius_in;
         if (cmd.fit_done) changed_ff <= 1'b0;
      end
   end

   // pixel capture, divider, squares
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff[0] <= ch0;
         px_ff[1] <= ch1;
         px_ff[2] <= ch2;
      end
      if (cmd.div_start) begin
         quot_ff <= num;
         rem_ff  <= '0;
         bit_ff  <= '0;
      end else if (cmd.div_step) begin
         bit_ff <= bit_ff + 1'b1;
         if (trial >= {1'b0, count_ff}) begin
            rem_ff  <= trial - {1'b0, count_ff};
            quot_ff <= {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff  <= trial;
            quot_ff <= {quot_ff[NW-2:0], 1'b0};
         end
      end
      sq_ff <= diff * diff;
      if (cmd.dist_clr) dist_ff <= '0;
      else if (cmd.dist_acc) dist_ff <= dist_ff + DW'(sq_ff);
   end

   assign in_sphere = (dist_ff <= radius_ff);

   assign status.count_zero    = (count_ff == '0);
   assign status.count_full    = (count_ff == CW'(MAX_SAMPLES));
   assign status.stats_changed = changed_ff;
   assign status.div_last      = (bit_ff == QCW'(NW - 1));

endmodule

// ===== hdl/css_control.sv =====
// -----------------------------------------------------------------------------
// css_control: sequencer for sample, clear and classify words
// Runs the fit (divide, radius) when needed, then the distance and compare.
// -----------------------------------------------------------------------------
module css_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [1:0]          in_action,
   output logic                in_ready,
   input  logic                out_busy,
   input  css_pkg::status_type status,
   output css_pkg::cmd_type    cmd,
   output logic                untrained_in
);
   css_pkg::state_type state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       sq_wait_ff, sq_wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= css_pkg::ST_IDLE;
         chan_ff    <= '0;
         sq_wait_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chan_ff    <= chan_in;
         sq_wait_ff <= sq_wait_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      sq_wait_in   = 1'b0;
      cmd          = '0;
      cmd.chan     = chan_ff;
      in_ready     = 1'b0;
      untrained_in = 1'b0;
      case (state_ff)
         css_pkg::ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_ready && in_valid;
            if (in_ready && in_valid) begin
               case (css_pkg::action_type'(in_action))
                  css_pkg::ACT_SAMPLE:   state_in = css_pkg::ST_OUT;
                  css_pkg::ACT_CLEAR:    cmd.clear_stats = 1'b1;
                  css_pkg::ACT_CLASSIFY: begin
                     state_in = css_pkg::ST_DIST;
                     chan_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         css_pkg::ST_OUT: begin
            // apply the captured sample unless the sample count is full
            cmd.add_sample = !status.count_full;
            state_in = css_pkg::ST_IDLE;
         end
         css_pkg::ST_DIST: begin
            // entry point of classify; an untrained word waits for a free output
            if (status.count_zero) begin
               if (!out_busy) begin
                  untrained_in = 1'b1;
                  cmd.load_out = 1'b1;
                  state_in     = css_pkg::ST_IDLE;
               end
            end else if (status.stats_changed) begin
               cmd.div_start = 1'b1;
               cmd.rad_clr   = 1'b1;
               state_in      = css_pkg::ST_DIV;
            end else begin
               cmd.dist_clr = 1'b1;
               state_in     = css_pkg::ST_CMP;
            end
         end
         css_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = css_pkg::ST_RAD;
         end
         css_pkg::ST_RAD: begin
            // store center, then square it against the channel maximum
            if (!sq_wait_ff) begin
               cmd.div_store = 1'b1;
               sq_wait_in    = 1'b1;
            end else begin
               cmd.sq_max = 1'b1;
               state_in   = css_pkg::ST_RACC;
            end
         end
         css_pkg::ST_RACC: begin
            // accumulate the radius term, then next channel or compare
            cmd.rad_acc = 1'b1;
            if (chan_ff == 2'd2) begin
               chan_in      = '0;
               cmd.fit_done = 1'b1;
               cmd.dist_clr = 1'b1;
               state_in     = css_pkg::ST_CMP;
            end else begin
               chan_in       = chan_ff + 1'b1;
               cmd.div_start = 1'b1;
               cmd.chan      = chan_ff + 1'b1;
               state_in      = css_pkg::ST_DIV;
            end
         end
         css_pkg::ST_CMP: begin
            // square of channel chan is ready the cycle after it is selected
            if (!sq_wait_ff) begin
               sq_wait_in = 1'b1;
            end else begin
               cmd.dist_acc = 1'b1;
               if (chan_ff == 2'd2) begin
                  chan_in  = '0;
                  state_in = css_pkg::ST_DONE;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end
         css_pkg::ST_DONE: begin
            // distance is complete; hold until the output register is free
            if (!out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = css_pkg::ST_IDLE;
            end
         end
         default: state_in = css_pkg::ST_IDLE;
      endcase
   end
endmodule
